>>> design/eer_pkg.sv
// ----------------------------------------------------------------------------
// eer_pkg
// Shared types, constants and functions of the emulated EEPROM block.
// ----------------------------------------------------------------------------
package eer_pkg;

	localparam int STORE_BYTES   = 4096;
	localparam int ADDR_W        = 12;
	localparam int MAX_ROW_BYTES = 256;
	localparam int MAX_ROWS      = 16;

	localparam logic [31:0] ROW_MAGIC = 32'h4F434657;
	localparam logic [7:0]  CRC_POLY  = 8'h31;
	localparam logic [7:0]  CRC_INIT  = 8'hFF;
	localparam logic [7:0]  ERASED    = 8'hFF;
	localparam logic [4:0]  HDR_BYTES = 5'd16;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_ERASE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPARAM = 2'd1,
		ST_NOROW    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_SIMPLE  = 2'd0,
		CFG_LSIZE   = 2'd1,
		CFG_RSIZE   = 2'd2,
		CFG_RCOUNT  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] offset;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_byte;
	} rsp_t;

	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_CLEAR,
		MOP_SWR,
		MOP_SRD,
		MOP_SCAN,
		MOP_XRD,
		MOP_CRD,
		MOP_CWR,
		MOP_HDR
	} mop_t;

	typedef struct packed {
		logic    take;
		mop_t    mop;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    scan_init;
		logic    crc_init;
		logic    row_eval;
		logic    row_next;
		logic    fin;
		logic    dst_sub;
		logic    cur_adv;
		logic    cur_reset;
		logic    res_load;
		status_t res_code;
	} cmd_t;

	typedef struct packed {
		logic       bad;
		logic       simple;
		logic [1:0] kind;
		logic       clear_last;
		logic       erase_last;
		logic       scan_last;
		logic       pay_last;
		logic       row_end_last;
		logic       row_last;
		logic       found;
		logic       dst_ge;
	} sts_t;

	function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
		logic [7:0] x;
		x = c ^ d;
		for (int i = 0; i < 8; i++) begin
			x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
		end
		return x;
	endfunction

endpackage

>>> design/eer_ifs.sv
// ----------------------------------------------------------------------------
// eer channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface eer_req_if import eer_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface eer_rsp_if import eer_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface eer_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/eer_datapath.sv
// ----------------------------------------------------------------------------
// eer_datapath
// Byte store, configuration, row scan, CRC and row rewrite datapath.
// ----------------------------------------------------------------------------
module eer_datapath import eer_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  req_t        req_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output rsp_t        rsp_data
);

	logic        simple_q;
	logic [12:0] lsize_q;
	logic [8:0]  rsize_q;
	logic [4:0]  rcount_q;
	logic [1:0]  kind_q;
	logic [11:0] off_q;
	logic [7:0]  wb_q;
	logic [12:0] cnt_q;
	logic [3:0]  row_q;
	logic [11:0] base_q;
	logic [31:0] magic_q;
	logic [31:0] seq_q;
	logic [7:0]  crcb_q;
	logic [7:0]  crc_q;
	logic        found_q;
	logic [3:0]  best_row_q;
	logic [31:0] best_seq_q;
	logic [3:0]  cur_row_q;
	logic [31:0] cur_seq_q;
	logic [4:0]  dst_q;
	logic        rd_scan_s1;
	logic [7:0]  rd_idx_s1;
	logic [7:0]  rdata_q;
	logic [7:0]  mem_q [STORE_BYTES];
	logic [1:0]  res_status_q;
	logic [7:0]  res_byte_q;

	logic [13:0]       region;
	logic [12:0]       best_base;
	logic [12:0]       dst_base;
	logic              cfg_ok;
	logic              row_ok;
	logic [31:0]       seq_diff;
	logic              newer;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_wdata;
	logic [7:0]        pay_byte;
	logic [7:0]        hdr_byte;
	logic              in_payload;

	assign region    = 14'(rcount_q) * 14'(rsize_q);
	assign best_base = 13'(best_row_q) * 13'(rsize_q);
	assign dst_base  = 13'(dst_q[3:0]) * 13'(rsize_q);

	always_comb begin
		cfg_ok = (lsize_q != 13'd0) && (rsize_q >= 9'd32) && (rsize_q <= 9'(MAX_ROW_BYTES))
			&& (rcount_q != 5'd0) && (rcount_q <= 5'(MAX_ROWS));
		if (simple_q) begin
			cfg_ok = cfg_ok && ({1'b0, lsize_q} <= region);
		end else begin
			cfg_ok = cfg_ok && (lsize_q <= ({4'b0, rsize_q} - 13'(HDR_BYTES)));
		end
	end

	assign seq_diff = seq_q - best_seq_q;
	assign newer    = !found_q || ((seq_diff != 32'd0) && !seq_diff[31]);
	assign row_ok   = (magic_q == ROW_MAGIC) && (crcb_q == crc_q);

	always_comb begin
		sts.bad = ((kind_q != KIND_READ) && (kind_q != KIND_WRITE) && (kind_q != KIND_ERASE))
			|| !cfg_ok || ((kind_q != KIND_ERASE) && ({1'b0, off_q} >= lsize_q));
		sts.simple       = simple_q;
		sts.kind         = kind_q;
		sts.clear_last   = (cnt_q[11:0] == {ADDR_W{1'b1}});
		sts.erase_last   = ({1'b0, cnt_q} == (region - 14'd1));
		sts.scan_last    = (cnt_q == (lsize_q + 13'd15));
		sts.pay_last     = (cnt_q == (lsize_q - 13'd1));
		sts.row_end_last = (cnt_q == ({4'b0, rsize_q} - 13'd1));
		sts.row_last     = ({1'b0, row_q} == (rcount_q - 5'd1));
		sts.found        = found_q;
		sts.dst_ge       = (dst_q >= rcount_q);
	end

	assign pay_byte   = ({1'b0, cnt_q[11:0]} == {1'b0, off_q}) ? wb_q :
		(found_q ? rdata_q : 8'd0);
	assign in_payload = (cnt_q >= 13'(HDR_BYTES)) && (cnt_q < (lsize_q + 13'(HDR_BYTES)));

	always_comb begin
		case (cnt_q[3:0])
			4'd0:    hdr_byte = ROW_MAGIC[7:0];
			4'd1:    hdr_byte = ROW_MAGIC[15:8];
			4'd2:    hdr_byte = ROW_MAGIC[23:16];
			4'd3:    hdr_byte = ROW_MAGIC[31:24];
			4'd4:    hdr_byte = cur_seq_q[7:0];
			4'd5:    hdr_byte = cur_seq_q[15:8];
			4'd6:    hdr_byte = cur_seq_q[23:16];
			4'd7:    hdr_byte = cur_seq_q[31:24];
			4'd8:    hdr_byte = crc_q;
			default: hdr_byte = ERASED;
		endcase
		if (cnt_q >= 13'(HDR_BYTES)) begin
			hdr_byte = ERASED;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cnt_q[11:0];
		mem_raddr = cnt_q[11:0];
		mem_wdata = ERASED;
		unique case (cmd.mop)
			MOP_CLEAR: begin
				mem_we = 1'b1;
			end
			MOP_SWR: begin
				mem_we    = 1'b1;
				mem_waddr = off_q;
				mem_wdata = wb_q;
			end
			MOP_SRD: begin
				mem_re    = 1'b1;
				mem_raddr = off_q;
			end
			MOP_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = base_q + cnt_q[11:0];
			end
			MOP_XRD: begin
				mem_re    = 1'b1;
				mem_raddr = best_base[11:0] + 12'(HDR_BYTES) + off_q;
			end
			MOP_CRD: begin
				mem_re    = 1'b1;
				mem_raddr = best_base[11:0] + 12'(HDR_BYTES) + cnt_q[11:0];
			end
			MOP_CWR: begin
				mem_we    = 1'b1;
				mem_waddr = dst_base[11:0] + 12'(HDR_BYTES) + cnt_q[11:0];
				mem_wdata = pay_byte;
			end
			MOP_HDR: begin
				mem_we    = !in_payload;
				mem_waddr = dst_base[11:0] + cnt_q[11:0];
				mem_wdata = hdr_byte;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			simple_q <= 1'b0;
			lsize_q  <= 13'd16;
			rsize_q  <= 9'd64;
			rcount_q <= 5'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIMPLE: simple_q <= cfg_data[0];
				CFG_LSIZE:  lsize_q  <= cfg_data;
				CFG_RSIZE:  rsize_q  <= cfg_data[8:0];
				CFG_RCOUNT: rcount_q <= cfg_data[4:0];
				default:    simple_q <= simple_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= req_data.kind;
			off_q  <= req_data.offset;
			wb_q   <= req_data.write_byte;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_byte_q   <= ((cmd.res_code == ST_OK) && (kind_q == KIND_READ)) ? rdata_q : 8'd0;
		end
		rd_idx_s1 <= cnt_q[7:0];
		if (rd_scan_s1) begin
			if (rd_idx_s1 < 8'd4) begin
				magic_q <= {rdata_q, magic_q[31:8]};
			end else if (rd_idx_s1 < 8'd8) begin
				seq_q <= {rdata_q, seq_q[31:8]};
			end else if (rd_idx_s1 == 8'd8) begin
				crcb_q <= rdata_q;
			end else if (rd_idx_s1 >= 8'(HDR_BYTES)) begin
				crc_q <= crc8_next(crc_q, rdata_q);
			end
		end else if (cmd.crc_init) begin
			crc_q <= CRC_INIT;
		end else if (cmd.mop == MOP_CWR) begin
			crc_q <= crc8_next(crc_q, pay_byte);
		end
		if (cmd.row_eval && row_ok && newer) begin
			best_row_q <= row_q;
			best_seq_q <= seq_q;
		end
		if (cmd.fin) begin
			dst_q <= 5'(found_q ? best_row_q : cur_row_q) + 5'd1;
		end else if (cmd.dst_sub) begin
			dst_q <= dst_q - rcount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 13'd0;
			row_q      <= 4'd0;
			base_q     <= '0;
			found_q    <= 1'b0;
			cur_row_q  <= 4'd0;
			cur_seq_q  <= 32'd0;
			rd_scan_s1 <= 1'b0;
		end else begin
			rd_scan_s1 <= (cmd.mop == MOP_SCAN);
			if (cmd.cnt_clr) begin
				cnt_q <= 13'd0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 13'd1;
			end
			if (cmd.scan_init) begin
				row_q   <= 4'd0;
				base_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.row_eval && row_ok) begin
					found_q <= 1'b1;
				end
				if (cmd.row_next) begin
					row_q  <= row_q + 4'd1;
					base_q <= base_q + 12'(rsize_q);
				end
			end
			if (cmd.cur_reset) begin
				cur_row_q <= 4'd0;
				cur_seq_q <= 32'd0;
			end else if (cmd.fin && found_q) begin
				cur_row_q <= best_row_q;
				cur_seq_q <= best_seq_q;
			end else if (cmd.cur_adv) begin
				cur_row_q <= dst_q[3:0];
				cur_seq_q <= cur_seq_q + 32'd1;
			end
		end
	end

	assign rsp_data.status    = res_status_q;
	assign rsp_data.read_byte = res_byte_q;

endmodule

>>> design/eer_ctrl.sv
// ----------------------------------------------------------------------------
// eer_ctrl
// Sequencer for clear, erase, direct access, row scan and row rewrite.
// ----------------------------------------------------------------------------
module eer_ctrl import eer_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [13:0] {
		S_CLEAR    = 14'b00000000000001,
		S_IDLE     = 14'b00000000000010,
		S_DECIDE   = 14'b00000000000100,
		S_ERASE    = 14'b00000000001000,
		S_SRD      = 14'b00000000010000,
		S_SCAN     = 14'b00000000100000,
		S_SCAN_END = 14'b00000001000000,
		S_EVAL     = 14'b00000010000000,
		S_FIN      = 14'b00000100000000,
		S_XRD      = 14'b00001000000000,
		S_DMOD     = 14'b00010000000000,
		S_COPY_RD  = 14'b00100000000000,
		S_COPY_WR  = 14'b01000000000000,
		S_HDR      = 14'b10000000000000
	} state_t;

	state_t  state_q, state_d;
	logic    done_q, done_d;
	status_t code_q, code_d;
	logic    out_vld_q;

	assign req_ready = (state_q == S_IDLE) && !done_q;
	assign rsp_valid = out_vld_q;

	always_comb begin
		state_d      = state_q;
		done_d       = done_q;
		code_d       = code_q;
		cmd          = '0;
		cmd.mop      = MOP_NONE;
		cmd.res_code = code_q;
		if (done_q) begin
			if (!out_vld_q || rsp_ready) begin
				cmd.res_load = 1'b1;
				done_d       = 1'b0;
			end
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cmd.mop     = MOP_CLEAR;
					cmd.cnt_inc = 1'b1;
					if (sts.clear_last) begin
						state_d = S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd.take = 1'b1;
						state_d  = S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (sts.bad) begin
						code_d  = ST_BADPARAM;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else if (sts.kind == KIND_ERASE) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_ERASE;
					end else if (sts.simple) begin
						if (sts.kind == KIND_READ) begin
							state_d = S_SRD;
						end else begin
							cmd.mop = MOP_SWR;
							code_d  = ST_OK;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						cmd.scan_init = 1'b1;
						cmd.crc_init  = 1'b1;
						cmd.cnt_clr   = 1'b1;
						state_d       = S_SCAN;
					end
				end
				S_ERASE: begin
					cmd.mop     = MOP_CLEAR;
					cmd.cnt_inc = 1'b1;
					if (sts.erase_last) begin
						cmd.cur_reset = 1'b1;
						code_d        = ST_OK;
						done_d        = 1'b1;
						state_d       = S_IDLE;
					end
				end
				S_SRD: begin
					cmd.mop = MOP_SRD;
					code_d  = ST_OK;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
				S_SCAN: begin
					cmd.mop     = MOP_SCAN;
					cmd.cnt_inc = 1'b1;
					if (sts.scan_last) begin
						state_d = S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					state_d = S_EVAL;
				end
				S_EVAL: begin
					cmd.row_eval = 1'b1;
					if (sts.row_last) begin
						state_d = S_FIN;
					end else begin
						cmd.row_next = 1'b1;
						cmd.crc_init = 1'b1;
						cmd.cnt_clr  = 1'b1;
						state_d      = S_SCAN;
					end
				end
				S_FIN: begin
					if (sts.kind == KIND_READ) begin
						if (sts.found) begin
							cmd.fin = 1'b1;
							state_d = S_XRD;
						end else begin
							code_d  = ST_NOROW;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						cmd.fin = 1'b1;
						state_d = S_DMOD;
					end
				end
				S_XRD: begin
					cmd.mop = MOP_XRD;
					code_d  = ST_OK;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
				S_DMOD: begin
					if (sts.dst_ge) begin
						cmd.dst_sub = 1'b1;
					end else begin
						cmd.cur_adv  = 1'b1;
						cmd.crc_init = 1'b1;
						cmd.cnt_clr  = 1'b1;
						state_d      = S_COPY_RD;
					end
				end
				S_COPY_RD: begin
					cmd.mop = MOP_CRD;
					state_d = S_COPY_WR;
				end
				S_COPY_WR: begin
					cmd.mop = MOP_CWR;
					if (sts.pay_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_HDR;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = S_COPY_RD;
					end
				end
				S_HDR: begin
					cmd.mop     = MOP_HDR;
					cmd.cnt_inc = 1'b1;
					if (sts.row_end_last) begin
						code_d  = ST_OK;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			done_q    <= 1'b0;
			code_q    <= ST_OK;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			code_q  <= code_d;
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/emulated_eeprom_row_rotation.sv
// ----------------------------------------------------------------------------
// emulated_eeprom_row_rotation
// Emulated EEPROM over a 4096-byte store with rotating rows.
// ----------------------------------------------------------------------------
// After reset the store is swept to 0xFF over all 4096 bytes, one byte per
// cycle; no request word is taken during the sweep, configuration writes are.
// The store has one write and one read port, so every figure below counts
// bytes. An erase sweeps rcount*rsize bytes to 0xFF. An extended read scans
// every row, reading its lsize+16 header and payload bytes; an extended
// write then copies the payload, reading and writing each byte, and writes
// the rsize-lsize header and tail bytes of the new row. One request is in
// flight at a time; a finished response word waits in the output register
// while the next request is taken.
module emulated_eeprom_row_rotation import eer_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	eer_req_if.sink   req,
	eer_rsp_if.source rsp,
	eer_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	eer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	eer_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_data  (rsp.data)
	);

endmodule

>>> design/eer_checker.sv
// ----------------------------------------------------------------------------
// eer_port_props
// Port-level checks of the emulated EEPROM block.
// ----------------------------------------------------------------------------
module eer_port_props import eer_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [7:0] rsp_byte
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_byte))
		else $error("response word dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request word taken while another is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_BADPARAM)
			|| (rsp_status == ST_NOROW))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_byte == 8'd0)
		else $error("failed request returns a nonzero byte");

endmodule

bind emulated_eeprom_row_rotation eer_port_props u_eer_port_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.data.status),
	.rsp_byte   (rsp.data.read_byte)
);
